// ----- rtl/gff_pkg.sv -----
package gff_pkg;

  localparam int MAX_SIDE   = 16;
  localparam int SIDE_W     = $clog2(MAX_SIDE);
  localparam int CELLS      = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W     = 2 * SIDE_W;
  localparam int CAT_W      = 4;
  localparam int DIM_W      = 5;
  localparam int EXT_W      = 5;
  localparam int ABS_W      = 6;
  localparam int OP_W       = 3;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK = 3'd0,
    OP_FIND  = 3'd1,
    OP_MARK  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_SET   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIT,
    ST_EVAL,
    ST_PAINT,
    ST_DONE
  } state_e;

  localparam logic [1:0] REG_COLS   = 2'd0;
  localparam logic [1:0] REG_ROWS   = 2'd1;
  localparam logic [1:0] REG_SINGLE = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    logic             single;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SIDE_W-1:0] start_col;
    logic [SIDE_W-1:0] start_row;
    logic [EXT_W-1:0]  item_width;
    logic [EXT_W-1:0]  item_height;
    logic              vertical;
    logic [CAT_W-1:0]  item_kind;
    logic              skip_occupancy;
    logic [CAT_W-1:0]  cell_kind;
  } item_t;

  typedef struct packed {
    logic              success;
    logic [SIDE_W-1:0] found_col;
    logic [SIDE_W-1:0] found_row;
    logic              found_vertical;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              occ_we;
    logic              occ_wd;
    logic              cat_we;
    logic [CAT_W-1:0]  cat_wd;
  } mem_req_t;

  typedef struct packed {
    logic             occ;
    logic [CAT_W-1:0] cat;
  } cell_t;

endpackage

// ----- rtl/grid_footprint_first_fit.sv -----
// grid_footprint_first_fit: occupancy and category store for a grid of up to
// 16 x 16 cells, with footprint check, first-fit search and footprint updates.
// slave stream: one transaction is one request, the operation in tuser and
// its operands in tdata; master stream: one result transaction per request.
// apb port: grid columns at 0x0, grid rows at 0x4, single cell mode at 0x8;
// write only while no request is in flight.
// a request is taken only while the sequencer is idle. it walks the covered
// cells one at a time through a single cell compare unit and one read port
// of the cell store: each cell is read, then evaluated; the walk stops at
// the first misfit, and a cell outside the grid fails without a read.
// find: each start cell and orientation is tried in turn, up to
// cols*rows*2 tries; mark and clear write the covered cells one at a time;
// set writes the category of one cell.
// after reset a clearing pass frees every cell and sets every category to
// wildcard, with s_axis_tready low until it ends; reset also loads the
// 8 x 8 grid in multi-cell mode.
// a result waits in the output register while the next request is taken;
// a stalled receiver holds the sequencer at the end of the following request.
module grid_footprint_first_fit import gff_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // start_col, start_row, item_width, item_height, vertical, item_kind,
  // skip_occupancy, cell_kind, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // success, found_col, found_row, found_vertical, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [DIM_W-1:0] cols_q;
  logic [DIM_W-1:0] rows_q;
  logic             single_q;
  logic             cfg_wr;
  logic [1:0]       reg_idx;
  cfg_t             cfg;
  item_t            item;
  res_t             res;
  logic             res_valid;
  logic             out_free;
  logic             out_load;
  mem_req_t         mem_req;
  cell_t            cell_rd;
  logic             clearing;
  logic             m_valid_q;
  res_t             m_res_q;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= DIM_W'(8);
      rows_q   <= DIM_W'(8);
      single_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COLS:   cols_q   <= pwdata[DIM_W-1:0];
        REG_ROWS:   rows_q   <= pwdata[DIM_W-1:0];
        REG_SINGLE: single_q <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COLS:   prdata = APB_DATA_W'(cols_q);
      REG_ROWS:   prdata = APB_DATA_W'(rows_q);
      REG_SINGLE: prdata = APB_DATA_W'(single_q);
      default:    prdata = '0;
    endcase
  end

  // sizes above the grid side saturate
  assign cfg.cols   = (cols_q > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : cols_q;
  assign cfg.rows   = (rows_q > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : rows_q;
  assign cfg.single = single_q;

  assign item.operation      = s_axis_tuser;
  assign item.start_col      = s_axis_tdata[3:0];
  assign item.start_row      = s_axis_tdata[7:4];
  assign item.item_width     = s_axis_tdata[12:8];
  assign item.item_height    = s_axis_tdata[17:13];
  assign item.vertical       = s_axis_tdata[18];
  assign item.item_kind      = s_axis_tdata[22:19];
  assign item.skip_occupancy = s_axis_tdata[23];
  assign item.cell_kind      = s_axis_tdata[27:24];

  gff_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .clearing_i  (clearing),
    .in_valid_i  (s_axis_tvalid),
    .in_item_i   (item),
    .in_ready_o  (s_axis_tready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .req_o       (mem_req),
    .cell_i      (cell_rd)
  );

  gff_cell_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .clearing_o (clearing),
    .cell_o     (cell_rd)
  );

  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = res_valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), m_res_q.found_vertical,
                          m_res_q.found_row, m_res_q.found_col, m_res_q.success};

endmodule

// ----- rtl/gff_cell_store.sv -----
module gff_cell_store import gff_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output logic     clearing_o,
  output cell_t    cell_o
);

  logic              occ_mem [CELLS];
  logic [CAT_W-1:0]  cat_mem [CELLS];
  logic              occ_q;
  logic [CAT_W-1:0]  cat_q;
  logic [ADDR_W-1:0] clr_addr_q;
  logic              clr_busy_q;

  // clearing pass after reset: one entry per cycle back to free and wildcard
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= ADDR_W'(clr_addr_q + 1'b1);
      if (clr_addr_q == ADDR_W'(CELLS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      occ_mem[clr_addr_q] <= 1'b0;
      cat_mem[clr_addr_q] <= '0;
    end else begin
      if (req_i.occ_we) begin
        occ_mem[req_i.addr] <= req_i.occ_wd;
      end
      if (req_i.cat_we) begin
        cat_mem[req_i.addr] <= req_i.cat_wd;
      end
    end
    if (req_i.rd_en) begin
      occ_q <= occ_mem[req_i.addr];
      cat_q <= cat_mem[req_i.addr];
    end
  end

  assign clearing_o = clr_busy_q;
  assign cell_o.occ = occ_q;
  assign cell_o.cat = cat_q;

endmodule

// ----- rtl/gff_cell_unit.sv -----
module gff_cell_unit import gff_pkg::*; (
  input  logic [DIM_W-1:0]  cols_i,
  input  logic [DIM_W-1:0]  rows_i,
  input  logic [ABS_W-1:0]  col_i,
  input  logic [ABS_W-1:0]  row_i,
  input  cell_t             cell_i,
  input  logic [CAT_W-1:0]  kind_i,
  input  logic              skip_i,
  output logic              inside_o,
  output logic [ADDR_W-1:0] addr_o,
  output logic              fit_o
);

  assign inside_o = (col_i < ABS_W'(cols_i)) && (row_i < ABS_W'(rows_i));
  // column-major layout: column in the upper address bits
  assign addr_o   = {col_i[SIDE_W-1:0], row_i[SIDE_W-1:0]};
  assign fit_o    = (skip_i || !cell_i.occ) && ((cell_i.cat == '0) || (cell_i.cat == kind_i));

endmodule

// ----- rtl/gff_seq.sv -----
module gff_seq import gff_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     clearing_i,
  input  logic     in_valid_i,
  input  item_t    in_item_i,
  output logic     in_ready_o,
  input  logic     out_free_i,
  output logic     res_valid_o,
  output res_t     res_o,
  output mem_req_t req_o,
  input  cell_t    cell_i
);

  state_e            state_q, state_d;
  item_t             item_q, item_d;
  logic [SIDE_W-1:0] bc_q, bc_d;
  logic [SIDE_W-1:0] br_q, br_d;
  logic              orient_q, orient_d;
  logic [EXT_W-1:0]  dc_q, dc_d;
  logic [EXT_W-1:0]  dr_q, dr_d;
  res_t              res_q, res_d;

  logic              is_find, is_set, in_find, grid_empty, take;
  logic [EXT_W-1:0]  spc, spr;
  logic              span_zero, row_wrap, last_cell;
  logic              more_row, more_col, more;
  logic [ABS_W-1:0]  abs_col, abs_row;
  logic              in_grid, fit, skip_eff;
  logic [ADDR_W-1:0] addr;
  logic              fp_pass, fp_fail;

  assign is_find    = item_q.operation == OP_FIND;
  assign is_set     = item_q.operation == OP_SET;
  assign in_find    = in_item_i.operation == OP_FIND;
  assign grid_empty = (cfg_i.cols == '0) || (cfg_i.rows == '0);
  assign skip_eff   = item_q.skip_occupancy && (item_q.operation == OP_CHECK);
  assign take       = in_valid_i && !clearing_i;

  always_comb begin
    if (cfg_i.single || is_set) begin
      spc = EXT_W'(1);
      spr = EXT_W'(1);
    end else if (orient_q) begin
      spc = item_q.item_height;
      spr = item_q.item_width;
    end else begin
      spc = item_q.item_width;
      spr = item_q.item_height;
    end
  end

  assign span_zero = (spc == '0) || (spr == '0);
  assign row_wrap  = EXT_W'(dr_q + 1'b1) == spr;
  assign last_cell = row_wrap && (EXT_W'(dc_q + 1'b1) == spc);
  assign more_row  = (DIM_W'(br_q) + DIM_W'(1)) < cfg_i.rows;
  assign more_col  = (DIM_W'(bc_q) + DIM_W'(1)) < cfg_i.cols;
  assign more      = !orient_q || more_row || more_col;

  assign abs_col = ABS_W'(bc_q) + ABS_W'(dc_q);
  assign abs_row = ABS_W'(br_q) + ABS_W'(dr_q);

  gff_cell_unit u_unit (
    .cols_i   (cfg_i.cols),
    .rows_i   (cfg_i.rows),
    .col_i    (abs_col),
    .row_i    (abs_row),
    .cell_i   (cell_i),
    .kind_i   (item_q.item_kind),
    .skip_i   (skip_eff),
    .inside_o (in_grid),
    .addr_o   (addr),
    .fit_o    (fit)
  );

  // an empty footprint fits at once; a cell outside the grid fails without a read
  assign fp_pass = ((state_q == ST_FIT) && span_zero) ||
                   ((state_q == ST_EVAL) && fit && last_cell);
  assign fp_fail = ((state_q == ST_FIT) && !span_zero && !in_grid) ||
                   ((state_q == ST_EVAL) && !fit);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (in_item_i.operation)
            OP_CHECK:                 state_d = ST_FIT;
            OP_FIND:                  state_d = grid_empty ? ST_DONE : ST_FIT;
            OP_MARK, OP_CLEAR, OP_SET: state_d = ST_PAINT;
            default:                  state_d = ST_DONE;
          endcase
        end
      end
      ST_FIT, ST_EVAL: begin
        if (fp_pass) begin
          state_d = ST_DONE;
        end else if (fp_fail) begin
          state_d = (is_find && more) ? ST_FIT : ST_DONE;
        end else if (state_q == ST_FIT) begin
          state_d = ST_EVAL;
        end else begin
          state_d = ST_FIT;
        end
      end
      ST_PAINT: begin
        if (span_zero || last_cell) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    req_o       = '0;
    req_o.addr  = addr;
    unique case (state_q)
      ST_IDLE: in_ready_o = !clearing_i;
      ST_FIT:  req_o.rd_en = !span_zero && in_grid;
      ST_EVAL: ;
      ST_PAINT: begin
        if (!span_zero && in_grid) begin
          if (is_set) begin
            req_o.cat_we = 1'b1;
            req_o.cat_wd = item_q.cell_kind;
          end else begin
            req_o.occ_we = 1'b1;
            req_o.occ_wd = item_q.operation == OP_MARK;
          end
        end
      end
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // counters and operands
  always_comb begin
    item_d   = item_q;
    bc_d     = bc_q;
    br_d     = br_q;
    orient_d = orient_q;
    dc_d     = dc_q;
    dr_d     = dr_q;
    res_d    = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          item_d   = in_item_i;
          bc_d     = in_find ? '0 : in_item_i.start_col;
          br_d     = in_find ? '0 : in_item_i.start_row;
          orient_d = in_find ? 1'b0 : in_item_i.vertical;
          dc_d     = '0;
          dr_d     = '0;
          res_d    = '0;
          // empty grid: only an empty footprint in multi-cell mode is reported, at the origin
          if (in_find && grid_empty) begin
            res_d.success = ((in_item_i.item_width == '0) || (in_item_i.item_height == '0)) &&
                            !cfg_i.single;
          end
        end
      end
      ST_FIT, ST_EVAL: begin
        if (fp_pass) begin
          res_d.success = 1'b1;
          if (is_find) begin
            res_d.found_col      = bc_q;
            res_d.found_row      = br_q;
            res_d.found_vertical = orient_q;
          end
        end else if (fp_fail) begin
          if (is_find && more) begin
            dc_d = '0;
            dr_d = '0;
            if (!orient_q) begin
              orient_d = 1'b1;
            end else begin
              orient_d = 1'b0;
              if (more_row) begin
                br_d = SIDE_W'(br_q + 1'b1);
              end else begin
                br_d = '0;
                bc_d = SIDE_W'(bc_q + 1'b1);
              end
            end
          end else begin
            res_d = '0;
          end
        end else if (state_q == ST_EVAL) begin
          if (row_wrap) begin
            dr_d = '0;
            dc_d = EXT_W'(dc_q + 1'b1);
          end else begin
            dr_d = EXT_W'(dr_q + 1'b1);
          end
        end
      end
      ST_PAINT: begin
        res_d.success = 1'b1;
        if (!(span_zero || last_cell)) begin
          if (row_wrap) begin
            dr_d = '0;
            dc_d = EXT_W'(dc_q + 1'b1);
          end else begin
            dr_d = EXT_W'(dr_q + 1'b1);
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    bc_q     <= bc_d;
    br_q     <= br_d;
    orient_q <= orient_d;
    dc_q     <= dc_d;
    dr_q     <= dr_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- tb/grid_footprint_first_fit_checker.sv -----
`timescale 1ns / 1ps

module grid_footprint_first_fit_checker import gff_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  // start_col, start_row, item_width, item_height, vertical, item_kind,
  // skip_occupancy, cell_kind, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // operation
  input  logic [OP_W-1:0]       s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // success, found_col, found_row, found_vertical, zero fill
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic [APB_DATA_W-1:0] prdata_i,
  input  logic                  pready_i,
  output int                    errors_o,
  output int                    outstanding_o
);

  logic                  occ_q [CELLS];
  logic [CAT_W-1:0]      cat_q [CELLS];
  logic [DIM_W-1:0]      cols_q;
  logic [DIM_W-1:0]      rows_q;
  logic                  single_q;
  res_t                  fit_results_q [$];
  res_t                  head_result;
  item_t                 request;
  logic [APB_DATA_W-1:0] reg_value;
  int                    err_count = 0;

  assign errors_o = err_count;

  // sizes above the grid side saturate
  function automatic int used_span(logic [DIM_W-1:0] size);
    return (size > MAX_SIDE) ? MAX_SIDE : int'(size);
  endfunction

  function automatic bit in_grid(int c, int r);
    return (c < used_span(cols_q)) && (r < used_span(rows_q));
  endfunction

  function automatic bit cell_fits(int c, int r, logic [CAT_W-1:0] kind, bit skip);
    int at;
    if (!in_grid(c, r)) return 1'b0;
    at = c * MAX_SIDE + r;
    if (!skip && occ_q[at]) return 1'b0;
    return (cat_q[at] == '0) || (cat_q[at] == kind);
  endfunction

  function automatic bit footprint_fits(int c, int r, int w, int h, bit vert,
                                        logic [CAT_W-1:0] kind, bit skip);
    int span_c, span_r, dc, dr;
    span_c = vert ? h : w;
    span_r = vert ? w : h;
    if (single_q) return cell_fits(c, r, kind, skip);
    for (dc = 0; dc < span_c; dc++)
      for (dr = 0; dr < span_r; dr++)
        if (!cell_fits(c + dc, r + dr, kind, skip)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void paint_footprint(item_t req, logic value);
    int span_c, span_r, dc, dr;
    span_c = req.vertical ? req.item_height : req.item_width;
    span_r = req.vertical ? req.item_width : req.item_height;
    if (single_q) begin
      span_c = 1;
      span_r = 1;
    end
    for (dc = 0; dc < span_c; dc++)
      for (dr = 0; dr < span_r; dr++)
        if (in_grid(req.start_col + dc, req.start_row + dr))
          occ_q[(req.start_col + dc) * MAX_SIDE + req.start_row + dr] = value;
  endfunction

  function automatic res_t apply_request(item_t req);
    res_t res;
    int   nc, nr, c, r;
    res = '0;
    nc = used_span(cols_q);
    nr = used_span(rows_q);
    case (req.operation)
      OP_CHECK: begin
        res.success = footprint_fits(req.start_col, req.start_row, req.item_width,
                                     req.item_height, req.vertical, req.item_kind,
                                     req.skip_occupancy);
      end
      OP_FIND: begin
        // column outer, row inner, horizontal tried before vertical
        for (c = 0; c < nc && !res.success; c++)
          for (r = 0; r < nr && !res.success; r++)
            if (footprint_fits(c, r, req.item_width, req.item_height, 1'b0,
                               req.item_kind, 1'b0)) begin
              res.success   = 1'b1;
              res.found_col = c[SIDE_W-1:0];
              res.found_row = r[SIDE_W-1:0];
            end else if (footprint_fits(c, r, req.item_width, req.item_height, 1'b1,
                                        req.item_kind, 1'b0)) begin
              res.success        = 1'b1;
              res.found_col      = c[SIDE_W-1:0];
              res.found_row      = r[SIDE_W-1:0];
              res.found_vertical = 1'b1;
            end
        // empty grid: an empty footprint still fits at the origin in multi-cell mode
        if ((nc == 0 || nr == 0) && (req.item_width == 0 || req.item_height == 0)
            && !single_q) begin
          res = '0;
          res.success = 1'b1;
        end
      end
      OP_MARK: begin
        paint_footprint(req, 1'b1);
        res.success = 1'b1;
      end
      OP_CLEAR: begin
        paint_footprint(req, 1'b0);
        res.success = 1'b1;
      end
      OP_SET: begin
        if (in_grid(req.start_col, req.start_row))
          cat_q[req.start_col * MAX_SIDE + req.start_row] = req.cell_kind;
        res.success = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic compare_field(input string what, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t %s: expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        occ_q[i] = 1'b0;
        cat_q[i] = '0;
      end
      cols_q   = 5'd8;
      rows_q   = 5'd8;
      single_q = 1'b0;
      fit_results_q.delete();
      outstanding_o <= 0;
    end else begin
      // results leave before the request of the same edge is predicted
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (fit_results_q.size() == 0) begin
          err_count++;
          $display("%0t result transaction: expected none, actual %0h",
                   $time, m_axis_tdata_i);
        end else begin
          head_result = fit_results_q.pop_front();
          compare_field("success", head_result.success, m_axis_tdata_i[0]);
          compare_field("found_col", head_result.found_col, m_axis_tdata_i[4:1]);
          compare_field("found_row", head_result.found_row, m_axis_tdata_i[8:5]);
          compare_field("found_vertical", head_result.found_vertical, m_axis_tdata_i[9]);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        request.operation      = s_axis_tuser_i;
        request.start_col      = s_axis_tdata_i[3:0];
        request.start_row      = s_axis_tdata_i[7:4];
        request.item_width     = s_axis_tdata_i[12:8];
        request.item_height    = s_axis_tdata_i[17:13];
        request.vertical       = s_axis_tdata_i[18];
        request.item_kind      = s_axis_tdata_i[22:19];
        request.skip_occupancy = s_axis_tdata_i[23];
        request.cell_kind      = s_axis_tdata_i[27:24];
        fit_results_q.push_back(apply_request(request));
      end
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[3:2])
            REG_COLS:   cols_q   = pwdata_i[DIM_W-1:0];
            REG_ROWS:   rows_q   = pwdata_i[DIM_W-1:0];
            REG_SINGLE: single_q = pwdata_i[0];
            default: ;
          endcase
        end else begin
          case (paddr_i[3:2])
            REG_COLS:   reg_value = APB_DATA_W'(cols_q);
            REG_ROWS:   reg_value = APB_DATA_W'(rows_q);
            REG_SINGLE: reg_value = APB_DATA_W'(single_q);
            default:    reg_value = prdata_i;
          endcase
          compare_field("register readback", reg_value, prdata_i);
        end
      end
      outstanding_o <= fit_results_q.size();
    end
  end

endmodule

// ----- tb/grid_footprint_first_fit_tb.sv -----
`timescale 1ns / 1ps

module grid_footprint_first_fit_tb;
  import gff_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // start_col, start_row, item_width, item_height, vertical, item_kind,
  // skip_occupancy, cell_kind, zero fill
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // operation
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // success, found_col, found_row, found_vertical, zero fill
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int errors;
  int outstanding;
  bit quiet     = 1'b0;
  int sent      = 0;
  int settings  = 0;
  int grid_cols = 8;
  int grid_rows = 8;

  grid_footprint_first_fit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  grid_footprint_first_fit_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .errors_o        (errors),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: bursts of stalls until the quiet tail of the run
  initial begin
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!quiet) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  function automatic item_t make_request(logic [OP_W-1:0] op, int sc, int sr, int w, int h,
                                         bit vert, int kind, bit skip, int ckind);
    item_t req;
    req.operation      = op;
    req.start_col      = SIDE_W'(sc);
    req.start_row      = SIDE_W'(sr);
    req.item_width     = EXT_W'(w);
    req.item_height    = EXT_W'(h);
    req.vertical       = vert;
    req.item_kind      = CAT_W'(kind);
    req.skip_occupancy = skip;
    req.cell_kind      = CAT_W'(ckind);
    return req;
  endfunction

  // finds stay small so a full scan stays short
  function automatic logic [EXT_W-1:0] pick_extent(bit cheap);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (cheap) return (roll < 5) ? EXT_W'($urandom_range(5, 10)) : EXT_W'($urandom_range(1, 4));
    if (roll < 5) return EXT_W'($urandom_range(17, 31));
    if (roll < 15) return EXT_W'($urandom_range(5, 16));
    return EXT_W'($urandom_range(1, 4));
  endfunction

  task automatic send_request(input item_t req, input int idle_pct);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.operation;
    s_axis_tdata  <= {{(IN_DATA_W-28){1'b0}}, req.cell_kind, req.skip_occupancy,
                      req.item_kind, req.vertical, req.item_height, req.item_width,
                      req.start_row, req.start_col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_grid(input int cols, input int rows, input bit single);
    wait_idle();
    apb_access(1'b1, REG_COLS, cols);
    apb_access(1'b1, REG_ROWS, rows);
    apb_access(1'b1, REG_SINGLE, APB_DATA_W'(single));
    apb_access(1'b0, REG_COLS, '0);
    apb_access(1'b0, REG_ROWS, '0);
    apb_access(1'b0, REG_SINGLE, '0);
    grid_cols = cols;
    grid_rows = rows;
    settings++;
  endtask

  task automatic run_phase(input int count, input int idle_pct);
    item_t req;
    int    roll, nc, nr;
    nc = (grid_cols > MAX_SIDE) ? MAX_SIDE : grid_cols;
    nr = (grid_rows > MAX_SIDE) ? MAX_SIDE : grid_rows;
    repeat (count) begin
      req  = '0;
      roll = $urandom_range(0, 99);
      if (roll < 28)      req.operation = OP_CHECK;
      else if (roll < 46) req.operation = OP_FIND;
      else if (roll < 64) req.operation = OP_MARK;
      else if (roll < 78) req.operation = OP_CLEAR;
      else if (roll < 95) req.operation = OP_SET;
      else                req.operation = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      // mostly start cells inside the grid in use
      req.start_col = (nc > 0 && $urandom_range(0, 7) != 0) ?
                      SIDE_W'($urandom_range(0, nc - 1)) : SIDE_W'($urandom_range(0, 15));
      req.start_row = (nr > 0 && $urandom_range(0, 7) != 0) ?
                      SIDE_W'($urandom_range(0, nr - 1)) : SIDE_W'($urandom_range(0, 15));
      req.item_width     = pick_extent(req.operation == OP_FIND);
      req.item_height    = pick_extent(req.operation == OP_FIND);
      req.vertical       = 1'($urandom_range(0, 1));
      req.skip_occupancy = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 9);
      req.item_kind = (roll < 6) ? CAT_W'($urandom_range(1, 3)) :
                      (roll < 9) ? CAT_W'($urandom_range(1, 15)) : '0;
      roll = $urandom_range(0, 9);
      req.cell_kind = (roll < 4) ? '0 :
                      (roll < 8) ? CAT_W'($urandom_range(1, 3)) : CAT_W'($urandom_range(1, 15));
      // sweep the whole grid now and then so occupancy does not saturate
      if (req.operation == OP_CLEAR && $urandom_range(0, 3) == 0) begin
        req.start_col   = '0;
        req.start_row   = '0;
        req.item_width  = EXT_W'(MAX_SIDE);
        req.item_height = EXT_W'(MAX_SIDE);
      end
      send_request(req, idle_pct);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset grid: 8 x 8, multi-cell
    apb_access(1'b0, REG_COLS, '0);
    apb_access(1'b0, REG_ROWS, '0);
    apb_access(1'b0, REG_SINGLE, '0);
    send_request(make_request(OP_SET,   2, 3, 1, 1, 0, 1, 0, 5), 30);
    send_request(make_request(OP_CHECK, 2, 3, 1, 1, 0, 5, 0, 0), 30);
    send_request(make_request(OP_CHECK, 2, 3, 1, 1, 0, 6, 0, 0), 30);
    send_request(make_request(OP_CHECK, 0, 0, 1, 1, 0, 0, 0, 0), 30);
    send_request(make_request(OP_CHECK, 2, 3, 1, 1, 0, 0, 0, 0), 30);
    send_request(make_request(OP_MARK,  0, 0, 3, 2, 0, 1, 0, 0), 30);
    send_request(make_request(OP_CHECK, 0, 0, 3, 2, 0, 1, 0, 0), 30);
    send_request(make_request(OP_CHECK, 0, 0, 3, 2, 0, 1, 1, 0), 30);
    send_request(make_request(OP_FIND, 15, 15, 2, 2, 1, 1, 1, 15), 30);
    send_request(make_request(OP_FIND,  0, 0, 1, 3, 0, 5, 0, 0), 30);
    send_request(make_request(OP_CHECK, 0, 0, 9, 1, 0, 1, 0, 0), 30);
    send_request(make_request(OP_CHECK, 7, 7, 2, 1, 1, 1, 0, 0), 30);
    // empty footprints
    send_request(make_request(OP_CHECK, 15, 15, 0, 0, 0, 1, 0, 0), 30);
    send_request(make_request(OP_FIND,  0, 0, 0, 3, 0, 1, 0, 0), 30);
    send_request(make_request(OP_MARK,  4, 4, 0, 5, 0, 1, 0, 0), 30);
    // writes outside the grid in use are dropped
    send_request(make_request(OP_MARK, 15, 15, 1, 1, 0, 1, 0, 0), 30);
    send_request(make_request(OP_SET,  12, 12, 1, 1, 0, 1, 0, 9), 30);
    send_request(make_request(OP_SET,   7, 7, 1, 1, 0, 1, 0, 15), 30);
    send_request(make_request(OP_CHECK, 7, 7, 1, 1, 0, 15, 0, 0), 30);
    send_request(make_request(OP_CLEAR, 0, 0, 16, 16, 0, 1, 0, 0), 30);
    send_request(make_request(OP_FIND,  0, 0, 8, 8, 0, 3, 0, 0), 30);
    send_request(make_request(OP_FIND,  0, 0, 16, 16, 0, 1, 0, 0), 30);
    send_request(make_request(OP_UNUSED_LO, 3, 3, 2, 2, 1, 7, 1, 7), 30);
    send_request(make_request(OP_UNUSED_HI, 15, 15, 31, 31, 1, 15, 1, 15), 30);
    send_request(make_request(OP_MARK,  0, 0, 31, 31, 0, 1, 0, 0), 30);
    send_request(make_request(OP_CLEAR, 0, 0, 31, 31, 1, 1, 0, 0), 30);

    apply_grid(16, 16, 1'b0);
    run_phase(250, 30);
    apply_grid(1, 1, 1'b0);
    run_phase(120, 0);
    apply_grid(16, 16, 1'b1);
    run_phase(220, 50);
    apply_grid(5, 12, 1'b0);
    run_phase(250, 20);
    // empty grid, then sizes past the side that saturate
    apply_grid(0, 6, 1'b0);
    run_phase(60, 10);
    apply_grid(31, 31, 1'b0);
    run_phase(250, 40);
    apply_grid(12, 1, 1'b1);
    run_phase(120, 0);
    apply_grid($urandom_range(1, 16), $urandom_range(1, 16), 1'($urandom_range(0, 1)));
    run_phase(300, 25);

    quiet = 1'b1;
    apply_grid(16, 16, 1'b0);
    run_phase(260, 0);
    wait_idle();
    repeat (16) @(posedge clk_i);

    $display("covered %0d requests over %0d grid settings: checks, finds, marks,", sent,
             settings);
    $display("clears, category writes and unused codes, empty to saturated grids");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/gff_pkg.sv
rtl/gff_cell_store.sv
rtl/gff_cell_unit.sv
rtl/gff_seq.sv
rtl/grid_footprint_first_fit.sv
tb/grid_footprint_first_fit_checker.sv
tb/grid_footprint_first_fit_tb.sv
